// ----- hw/rtl/mssc_pkg.sv -----
`default_nettype none
package mssc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = 3;
  localparam int SUM_W = CNT_W + 1;
  localparam int ROOT_W = 7;
  localparam int SQ_W = 13;
  localparam logic [SUM_W-1:0] BEST_INIT = SUM_W'(7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ENTRY,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_LOOK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load_tgt;
    logic lookup;
    logic res_zero;
    logic res_mem;
    logic begin_entry;
    logic write_square;
    logic scan_init;
    logic scan_step;
    logic write_best;
  } cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic need_fill;
    logic is_square;
    logic last_j;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mssc_dp.sv -----
`default_nettype none
module mssc_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mssc_pkg::cmd_t                   cmd,
  input  wire logic [mssc_pkg::ADDR_W-1:0]      target,
  output mssc_pkg::status_t                     status,
  output logic      [mssc_pkg::CNT_W-1:0]       square_count
);

  logic [mssc_pkg::CNT_W-1:0] mem [mssc_pkg::TABLE_DEPTH];

  logic [mssc_pkg::ADDR_W-1:0] tgt;
  logic [mssc_pkg::ADDR_W-1:0] filled;
  logic [mssc_pkg::ADDR_W-1:0] idx;
  logic [mssc_pkg::ADDR_W-1:0] j;
  logic [mssc_pkg::ROOT_W-1:0] root;
  logic [mssc_pkg::SQ_W-1:0]   square;
  logic [mssc_pkg::SUM_W-1:0]  best;
  logic                        pair_valid;
  logic [mssc_pkg::CNT_W-1:0]  rd_a;
  logic [mssc_pkg::CNT_W-1:0]  rd_b;
  logic [mssc_pkg::CNT_W-1:0]  result;

  logic [mssc_pkg::ADDR_W-1:0] addr_a;
  logic [mssc_pkg::ADDR_W-1:0] addr_b;
  logic                        wr_en;
  logic [mssc_pkg::ADDR_W-1:0] wr_addr;
  logic [mssc_pkg::CNT_W-1:0]  wr_data;
  logic [mssc_pkg::SUM_W-1:0]  pair_sum;

  assign addr_a  = cmd.lookup ? tgt : j;
  assign addr_b  = idx - j;
  assign wr_en   = cmd.write_square || cmd.write_best;
  assign wr_addr = idx;
  assign wr_data = cmd.write_square ? mssc_pkg::CNT_W'(1) : best[mssc_pkg::CNT_W-1:0];
  assign pair_sum = {1'b0, rd_a} + {1'b0, rd_b};

  assign status.tgt_zero  = (tgt == '0);
  assign status.need_fill = (filled < tgt);
  assign status.is_square = ({1'b0, idx} == square);
  assign status.last_j    = (j == (idx >> 1));

  assign square_count = result;

  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled     <= '0;
      root       <= mssc_pkg::ROOT_W'(1);
      square     <= mssc_pkg::SQ_W'(1);
      pair_valid <= 1'b0;
    end else begin
      pair_valid <= cmd.scan_step;
      if (wr_en) begin
        filled <= idx;
      end
      if (cmd.write_square) begin
        square <= square + mssc_pkg::SQ_W'({root, 1'b1});
        root   <= root + mssc_pkg::ROOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tgt) begin
      tgt <= target;
    end
    if (cmd.begin_entry) begin
      idx <= filled + mssc_pkg::ADDR_W'(1);
    end
    if (cmd.scan_init) begin
      j    <= mssc_pkg::ADDR_W'(1);
      best <= mssc_pkg::BEST_INIT;
    end else begin
      if (cmd.scan_step) begin
        j <= j + mssc_pkg::ADDR_W'(1);
      end
      if (pair_valid && (pair_sum < best)) begin
        best <= pair_sum;
      end
    end
    if (cmd.res_zero) begin
      result <= '0;
    end else if (cmd.res_mem) begin
      result <= rd_a;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mssc_ctrl.sv -----
`default_nettype none
module mssc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire mssc_pkg::status_t   status,
  output mssc_pkg::cmd_t           cmd,
  output logic                     busy,
  output logic                     done
);

  mssc_pkg::state_t state;
  mssc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mssc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      mssc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_tgt = 1'b1;
          state_next   = mssc_pkg::ST_CHECK;
        end
      end
      mssc_pkg::ST_CHECK: begin
        priority if (status.tgt_zero) begin
          cmd.res_zero = 1'b1;
          state_next   = mssc_pkg::ST_RESP;
        end else if (status.need_fill) begin
          cmd.begin_entry = 1'b1;
          state_next      = mssc_pkg::ST_ENTRY;
        end else begin
          cmd.lookup = 1'b1;
          state_next = mssc_pkg::ST_LOOK;
        end
      end
      mssc_pkg::ST_ENTRY: begin
        if (status.is_square) begin
          cmd.write_square = 1'b1;
          state_next       = mssc_pkg::ST_CHECK;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = mssc_pkg::ST_SCAN;
        end
      end
      mssc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.last_j) begin
          state_next = mssc_pkg::ST_DRAIN;
        end
      end
      mssc_pkg::ST_DRAIN: begin
        state_next = mssc_pkg::ST_WRITE;
      end
      mssc_pkg::ST_WRITE: begin
        cmd.write_best = 1'b1;
        state_next     = mssc_pkg::ST_CHECK;
      end
      mssc_pkg::ST_LOOK: begin
        cmd.res_mem = 1'b1;
        state_next  = mssc_pkg::ST_RESP;
      end
      mssc_pkg::ST_RESP: begin
        done       = 1'b1;
        state_next = mssc_pkg::ST_IDLE;
      end
      default: begin
        state_next = mssc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/min_square_sum_count_dp.sv -----
`default_nettype none
// Returns the fewest perfect squares that sum to a 12-bit target, from a
// 4096-entry table of 3-bit counts that is kept from one query to the next.
// A query beat is taken at a rising edge where start is high and busy is low.
// The result beat is on square_count for exactly one cycle while done is high.
// A target of zero answers 0 by way of the check and response states.
// A target at or below the highest filled entry costs one table read and
// answers by way of the check, lookup and response states.
// A higher target first fills every entry above the filled mark up to it.
// A perfect-square entry is written as 1 from the entry state; any other entry i
// is scanned over the splits j + (i - j) for j from 1 to i/2, one pair of entries
// per cycle through the two read ports of the table, and gets the smallest sum.
// Only one query is in flight; busy stays high until done has been shown.
// The next query can be taken in the cycle after done.
// Reset empties the filled mark and the square tracker; it does not clear the
// table, since no entry is read before it is written.
// The receiver cannot stall, so done is never held.
module min_square_sum_count_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mssc_pkg::ADDR_W-1:0]   target,
  output logic                               done,
  output logic      [mssc_pkg::CNT_W-1:0]    square_count
);

  mssc_pkg::cmd_t    cmd;
  mssc_pkg::status_t status;

  mssc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mssc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .target       (target),
    .status       (status),
    .square_count (square_count)
  );

endmodule
`default_nettype wire
